>>> src/eht_pkg.sv
// Shared types and constants for the extendible hash table unit.
// No dependencies.
`default_nettype none
package eht_pkg;

  localparam int MAX_DEPTH    = 8;
  localparam int BUCKET_SLOTS = 4;
  localparam int DIR_DEPTH    = 1 << MAX_DEPTH;

  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [3:0]  global_depth;
    logic [8:0]  bucket_count;
  } rsp_word_t;

  typedef struct packed {
    logic [BUCKET_SLOTS-1:0][31:0] keys;
    logic [BUCKET_SLOTS-1:0][31:0] vals;
    logic [2:0]                    occ;
    logic [3:0]                    ld;
  } bucket_row_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIR_RD, S_BKT_RD, S_EXEC,
    S_DBL_RD, S_DBL_WR, S_SPLIT_LO, S_SPLIT_HI, S_REP_RD, S_REP_WR
  } eht_state_t;

  typedef struct packed {
    logic clr_wr;
    logic take_req;
    logic dir_rd_key;
    logic row_rd;
    logic row_wr_exec;
    logic walk_init;
    logic walk_inc;
    logic dbl_rd;
    logic dbl_wr;
    logic gd_inc;
    logic split_wr_lo;
    logic split_wr_hi;
    logic rep_rd;
    logic rep_wr;
    logic used_inc;
    logic done;
    logic full;
  } eht_cmd_t;

  typedef struct packed {
    logic need_split;
    logic need_dbl;
    logic at_max;
    logic walk_last;
    logic clr_last;
  } eht_sts_t;

endpackage
`default_nettype wire

>>> src/eht_datapath.sv
// Datapath: directory and bucket memories, depth counters, result register.
// Depends on eht_pkg.
`default_nettype none
module eht_datapath import eht_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_word_t req,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_wdata,
  input  wire eht_cmd_t  cmd,
  output eht_sts_t       sts,
  output logic           done,
  output rsp_word_t      result
);

  logic [7:0]  dir_mem [DIR_DEPTH];
  bucket_row_t row_mem [DIR_DEPTH];

  req_word_t   req_q;
  logic [2:0]  bsize;
  logic [3:0]  gd;
  logic [8:0]  used;
  logic [7:0]  bidx;
  logic [8:0]  wi;
  logic [7:0]  dir_q;
  bucket_row_t row_q;

  logic [7:0]  mask8;
  logic [8:0]  n;
  logic [7:0]  dir_key;
  logic [2:0]  lim;
  logic        hit;
  logic [1:0]  hs;
  logic        is_find, is_ins, is_rem;
  logic        exec_we;
  logic [2:0]  last;
  logic [2:0]  bitsel;
  logic [2:0]  kl, km;
  bucket_row_t exec_row, lo_row, hi_row;

  assign mask8   = 8'((9'd1 << gd) - 9'd1);
  assign n       = 9'd1 << gd;
  assign dir_key = req_q.key[7:0] & mask8;
  assign is_find = req_q.req_type == REQ_FIND;
  assign is_ins  = req_q.req_type == REQ_INSERT;
  assign is_rem  = req_q.req_type == REQ_REMOVE;
  assign bitsel  = row_q.ld[2:0];
  assign last    = row_q.occ - 3'd1;

  always_comb begin
    if (bsize == 3'd0) lim = 3'd1;
    else if (bsize > 3'(BUCKET_SLOTS)) lim = 3'(BUCKET_SLOTS);
    else lim = bsize;
  end

  always_comb begin
    hit = 1'b0;
    hs  = 2'd0;
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      if (!hit && 3'(i) < row_q.occ && row_q.keys[i] == req_q.key) begin
        hit = 1'b1;
        hs  = 2'(i);
      end
    end
  end

  always_comb begin
    exec_row = row_q;
    exec_we  = 1'b0;
    if (is_ins) begin
      exec_we = 1'b1;
      if (hit) begin
        exec_row.vals[hs] = req_q.value;
      end else begin
        exec_row.keys[row_q.occ[1:0]] = req_q.key;
        exec_row.vals[row_q.occ[1:0]] = req_q.value;
        exec_row.occ = row_q.occ + 3'd1;
      end
    end else if (is_rem && hit) begin
      exec_we = 1'b1;
      exec_row.keys[hs] = row_q.keys[last[1:0]];
      exec_row.vals[hs] = row_q.vals[last[1:0]];
      exec_row.occ = last;
    end
  end

  // split the held bucket on key bit ld
  always_comb begin
    lo_row = '0;
    hi_row = '0;
    kl = 3'd0;
    km = 3'd0;
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      if (3'(i) < row_q.occ) begin
        if (row_q.keys[i][bitsel]) begin
          hi_row.keys[km[1:0]] = row_q.keys[i];
          hi_row.vals[km[1:0]] = row_q.vals[i];
          km = km + 3'd1;
        end else begin
          lo_row.keys[kl[1:0]] = row_q.keys[i];
          lo_row.vals[kl[1:0]] = row_q.vals[i];
          kl = kl + 3'd1;
        end
      end
    end
    lo_row.occ = kl;
    hi_row.occ = km;
    lo_row.ld  = row_q.ld + 4'd1;
    hi_row.ld  = row_q.ld + 4'd1;
  end

  assign sts.need_split = is_ins && !hit && row_q.occ >= lim;
  assign sts.need_dbl   = row_q.ld >= gd;
  assign sts.at_max     = gd >= 4'(MAX_DEPTH);
  assign sts.walk_last  = wi == n - 9'd1;
  assign sts.clr_last   = wi == 9'(DIR_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      dir_mem[wi[7:0]] <= 8'd0;
    end else if (cmd.dbl_wr) begin
      dir_mem[8'(wi + n)] <= dir_q;
    end else if (cmd.rep_wr && dir_q == bidx && wi[bitsel]) begin
      dir_mem[wi[7:0]] <= used[7:0];
    end
    if (cmd.dir_rd_key) begin
      dir_q <= dir_mem[dir_key];
    end else if (cmd.dbl_rd || cmd.rep_rd) begin
      dir_q <= dir_mem[wi[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      row_mem[wi[7:0]] <= '0;
    end else if (cmd.row_wr_exec && exec_we) begin
      row_mem[bidx] <= exec_row;
    end else if (cmd.split_wr_lo) begin
      row_mem[bidx] <= lo_row;
    end else if (cmd.split_wr_hi) begin
      row_mem[used[7:0]] <= hi_row;
    end
    if (cmd.row_rd) begin
      row_q <= row_mem[dir_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) req_q <= req;
    if (cmd.row_rd) bidx <= dir_q;
    if (cmd.done) begin
      if (cmd.full) result.status <= ST_FULL;
      else if ((is_find || is_rem) && !hit) result.status <= ST_MISS;
      else result.status <= ST_DONE;
      result.found_value  <= (is_find && hit) ? row_q.vals[hs] : 32'd0;
      result.global_depth <= gd;
      result.bucket_count <= used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bsize <= 3'd4;
      gd    <= 4'd0;
      used  <= 9'd1;
      wi    <= 9'd0;
      done  <= 1'b0;
    end else begin
      done <= cmd.done;
      if (cfg_we) bsize <= cfg_wdata;
      if (cmd.gd_inc) gd <= gd + 4'd1;
      if (cmd.used_inc) used <= used + 9'd1;
      if (cmd.walk_init) wi <= 9'd0;
      else if (cmd.walk_inc) wi <= wi + 9'd1;
    end
  end

endmodule
`default_nettype wire

>>> src/eht_controller.sv
// Controller state machine: sequences lookups, doublings, splits and clearing.
// Depends on eht_pkg.
`default_nettype none
module eht_controller import eht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire eht_sts_t sts,
  output eht_cmd_t      cmd,
  output logic          busy
);

  eht_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.walk_init = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.take_req = 1'b1;
          state_next = S_DIR_RD;
        end
      end
      S_DIR_RD: begin
        cmd.dir_rd_key = 1'b1;
        state_next = S_BKT_RD;
      end
      S_BKT_RD: begin
        cmd.row_rd = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.need_split) begin
          cmd.row_wr_exec = 1'b1;
          cmd.done = 1'b1;
          state_next = S_IDLE;
        end else if (sts.need_dbl && sts.at_max) begin
          cmd.done = 1'b1;
          cmd.full = 1'b1;
          state_next = S_IDLE;
        end else if (sts.need_dbl) begin
          cmd.walk_init = 1'b1;
          state_next = S_DBL_RD;
        end else begin
          state_next = S_SPLIT_LO;
        end
      end
      S_DBL_RD: begin
        cmd.dbl_rd = 1'b1;
        state_next = S_DBL_WR;
      end
      S_DBL_WR: begin
        cmd.dbl_wr = 1'b1;
        if (sts.walk_last) begin
          cmd.gd_inc = 1'b1;
          state_next = S_SPLIT_LO;
        end else begin
          cmd.walk_inc = 1'b1;
          state_next = S_DBL_RD;
        end
      end
      S_SPLIT_LO: begin
        cmd.split_wr_lo = 1'b1;
        cmd.walk_init = 1'b1;
        state_next = S_SPLIT_HI;
      end
      S_SPLIT_HI: begin
        cmd.split_wr_hi = 1'b1;
        state_next = S_REP_RD;
      end
      S_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_next = S_REP_WR;
      end
      S_REP_WR: begin
        cmd.rep_wr = 1'b1;
        if (sts.walk_last) begin
          cmd.used_inc = 1'b1;
          state_next = S_DIR_RD;
        end else begin
          cmd.walk_inc = 1'b1;
          state_next = S_REP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/extendible_hash_table_unit.sv
// Top level of the extendible hash table unit: controller plus datapath.
// Depends on eht_pkg, eht_controller, eht_datapath.
//
//   channel  | handshake         | word
//   request  | start / busy      | req (req_type, key, value)
//   result   | done (strobe)     | result (status, found_value, global_depth, bucket_count)
//   config   | cfg_we            | cfg_wdata (bucket_size)
//
// A find, remove, overwrite or plain insert goes from accept through directory read,
// bucket read and execute to done. An insert into a full bucket first doubles the
// directory when needed, copying each current entry, then splits the bucket and
// repoints the directory entries that now select the new bucket, then retries.
// After reset busy stays high while all 256 directory entries and buckets clear.
// done is a one-cycle strobe; the result cannot be held off.
`default_nettype none
module extendible_hash_table_unit import eht_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire req_word_t  req,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  output logic            done,
  output rsp_word_t       result
);

  eht_cmd_t cmd;
  eht_sts_t sts;

  eht_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  eht_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule
`default_nettype wire

>>> bench/tb_extendible_hash_table_unit.sv
// Self-checking bench for extendible_hash_table_unit: directed table then random requests.
// Expected words come from an in-bench model of the table; depends on eht_pkg.
`timescale 1ns / 1ps
module tb_extendible_hash_table_unit;
  import eht_pkg::*;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  req_word_t req;
  logic      cfg_we;
  logic [2:0] cfg_wdata;
  logic      done;
  rsp_word_t result;

  extendible_hash_table_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("extendible_hash_table_unit: mismatch");
    $finish;
  end

  // table model
  logic [2:0]  m_bsize;
  logic [3:0]  m_gd;
  logic [7:0]  m_dir [DIR_DEPTH];
  logic [3:0]  m_ld [DIR_DEPTH];
  logic [2:0]  m_occ [DIR_DEPTH];
  logic [31:0] m_key [DIR_DEPTH][BUCKET_SLOTS];
  logic [31:0] m_val [DIR_DEPTH][BUCKET_SLOTS];
  logic [8:0]  m_used;

  rsp_word_t expected_words[$];
  int        errors;
  logic [31:0] key_pool[$];

  function automatic int lim();
    if (m_bsize == 0) return 1;
    if (m_bsize > BUCKET_SLOTS) return BUCKET_SLOTS;
    return m_bsize;
  endfunction

  function automatic int dir_of(logic [31:0] k);
    return int'(k & ((32'd1 << m_gd) - 1));
  endfunction

  function automatic int slot_of(int b, logic [31:0] k);
    for (int i = 0; i < m_occ[b] && i < BUCKET_SLOTS; i++)
      if (m_key[b][i] == k) return i;
    return -1;
  endfunction

  task automatic table_reset();
    m_bsize = 3'd4; m_gd = 0; m_used = 1;
    for (int i = 0; i < DIR_DEPTH; i++) begin
      m_dir[i] = 0; m_ld[i] = 0; m_occ[i] = 0;
    end
  endtask

  task automatic split(int b);
    int d, nb, keep, moved, n;
    logic [31:0] k, v;
    d = m_ld[b]; nb = m_used; keep = 0; moved = 0;
    m_used++;
    m_ld[b] = d + 1; m_ld[nb] = d + 1;
    for (int i = 0; i < m_occ[b] && i < BUCKET_SLOTS; i++) begin
      k = m_key[b][i]; v = m_val[b][i];
      if (k[d]) begin
        m_key[nb][moved] = k; m_val[nb][moved] = v; moved++;
      end else begin
        m_key[b][keep] = k; m_val[b][keep] = v; keep++;
      end
    end
    m_occ[b] = keep; m_occ[nb] = moved;
    n = 1 << m_gd;
    for (int i = 0; i < n; i++)
      if (m_dir[i] == b && ((i >> d) & 1)) m_dir[i] = nb;
  endtask

  task automatic table_apply(req_word_t w, output rsp_word_t r);
    int b, s, n, last;
    r = '0;
    b = m_dir[dir_of(w.key)];
    s = slot_of(b, w.key);
    case (w.req_type)
      REQ_FIND: begin
        if (s >= 0) r.found_value = m_val[b][s];
        else r.status = ST_MISS;
      end
      REQ_INSERT: begin
        if (s >= 0) m_val[b][s] = w.value;
        else begin
          while (m_occ[b] >= lim() && r.status != ST_FULL) begin
            if (m_ld[b] >= m_gd) begin
              if (m_gd >= MAX_DEPTH) r.status = ST_FULL;
              else begin
                n = 1 << m_gd;
                for (int i = 0; i < n; i++) m_dir[i + n] = m_dir[i];
                m_gd++;
              end
            end
            if (r.status != ST_FULL) begin
              split(b);
              b = m_dir[dir_of(w.key)];
            end
          end
          if (r.status != ST_FULL) begin
            m_key[b][m_occ[b]] = w.key; m_val[b][m_occ[b]] = w.value;
            m_occ[b]++;
          end
        end
      end
      REQ_REMOVE: begin
        if (s >= 0) begin
          last = m_occ[b] - 1;
          m_key[b][s] = m_key[b][last]; m_val[b][s] = m_val[b][last];
          m_occ[b] = last;
        end else r.status = ST_MISS;
      end
      default: ;
    endcase
    r.global_depth = m_gd;
    r.bucket_count = m_used;
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_word_t e;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, result);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (result.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, result.status);
        if (result.found_value !== e.found_value)
          $display("%0t: found_value exp %h got %h", $time, e.found_value, result.found_value);
        if (result.global_depth !== e.global_depth)
          $display("%0t: global_depth exp %0d got %0d", $time, e.global_depth,
                   result.global_depth);
        if (result.bucket_count !== e.bucket_count)
          $display("%0t: bucket_count exp %0d got %0d", $time, e.bucket_count,
                   result.bucket_count);
        if (result !== e) errors++;
      end
    end
  end

  int burst_left;

  task automatic send_word(req_word_t w, bit has_exp, rsp_word_t exp_w);
    rsp_word_t r;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start = 1'b1; req = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_apply(w, r);
    if (has_exp && r !== exp_w) begin
      $display("%0t: table row exp %h model %h", $time, exp_w, r);
      errors++;
    end
    expected_words = {expected_words, r};
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain_and_config(logic [2:0] v);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we = 1'b1; cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    m_bsize = v;
  endtask

  function automatic logic [31:0] pick_key(int mode);
    if (mode == 0 && key_pool.size() > 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (mode == 1) return {24'd0, 4'($urandom_range(0, 15)), 4'($urandom)};
    return $urandom;
  endfunction

  typedef struct {
    req_word_t w;
    bit        has_exp;
    rsp_word_t e;
  } dir_row_t;

  dir_row_t rows[$];

  function automatic dir_row_t mk(req_code_t t, logic [31:0] k, logic [31:0] v,
                                  bit he, logic [1:0] st, logic [31:0] fv,
                                  logic [3:0] gd, logic [8:0] bc);
    dir_row_t d;
    d.w = '{req_type: t, key: k, value: v};
    d.has_exp = he;
    d.e = '{status: st, found_value: fv, global_depth: gd, bucket_count: bc};
    return d;
  endfunction

  initial begin
    rsp_word_t dummy;
    req_word_t w;
    int phase, mode;
    logic [2:0] sizes[6] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3};
    errors = 0; burst_left = 0;
    rst = 1'b1; start = 1'b0; req = '0; cfg_we = 1'b0; cfg_wdata = 3'd4;
    table_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows = {rows, mk(REQ_FIND, 32'h0, 32'h0, 1, ST_MISS, 0, 0, 1)};
    rows = {rows, mk(REQ_REMOVE, 32'hFFFFFFFF, 32'h0, 1, ST_MISS, 0, 0, 1)};
    rows = {rows, mk(REQ_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, ST_DONE, 0, 0, 1)};
    rows = {rows, mk(REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, ST_DONE, 0, 0, 1)};
    rows = {rows, mk(REQ_FIND, 32'hFFFFFFFF, 32'h0, 1, ST_DONE, 32'hFFFFFFFF, 0, 1)};
    rows = {rows, mk(REQ_INSERT, 32'h0, 32'h0, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_INSERT, 32'h0, 32'h12345678, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_INSERT, 32'h2, 32'h2, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_INSERT, 32'h4, 32'h4, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_INSERT, 32'h6, 32'h6, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_FIND, 32'h0, 32'h0, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_REMOVE, 32'h0, 32'h0, 0, ST_DONE, 0, 0, 0)};
    rows = {rows, mk(REQ_FIND, 32'h6, 32'h0, 0, ST_DONE, 0, 0, 0)};
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].e);

    // size 1 with keys sharing low bits forces the depth limit
    drain_and_config(3'd1);
    for (int i = 0; i < 4; i++) begin
      w = '{req_type: REQ_INSERT, key: 32'h1000 * i, value: $urandom};
      send_word(w, 0, dummy);
    end
    w = '{req_type: REQ_FIND, key: 32'h1000, value: 32'h0};
    send_word(w, 0, dummy);

    for (phase = 0; phase < 6; phase++) begin
      drain_and_config(sizes[phase]);
      for (int n = 0; n < 175; n++) begin
        mode = $urandom_range(0, 9);
        w.req_type = req_code_t'($urandom_range(0, 9) < 5 ? REQ_INSERT :
                     ($urandom_range(0, 9) == 0 ? REQ_NOP : $urandom_range(0, 2)));
        w.key = pick_key(mode < 5 ? 0 : (mode < 8 ? 1 : 2));
        w.value = $urandom;
        if (w.req_type == REQ_INSERT && key_pool.size() < 64) key_pool = {key_pool, w.key};
        send_word(w, 0, dummy);
      end
    end

    while (expected_words.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("extendible_hash_table_unit: match");
    end else begin
      $display("extendible_hash_table_unit: mismatch");
    end
    $finish;
  end

endmodule
